// ===== rtl/qbvg_pkg.sv =====
// Package for the quad batch vertex generator: transaction payload structs,
// opcodes, result kinds, register indexes and controller/datapath links.
// No dependencies.
package qbvg_pkg;

	localparam int MAX_SLOTS_DEF       = 16;
	localparam int MAX_BATCH_QUADS_DEF = 4096;

	localparam int BQ_W   = 13;
	localparam int SL_W   = 5;
	localparam int CFG_DW = 13;
	localparam int CFG_IW = 1;

	localparam logic [BQ_W-1:0] BQ_RESET = 13'd4096;
	localparam logic [SL_W-1:0] SL_RESET = 5'd16;

	localparam logic [CFG_IW-1:0] CFG_BATCH_QUADS = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_SLOT_LIMIT  = 1'b1;

	localparam logic [1:0] OP_QUAD  = 2'd0;
	localparam logic [1:0] OP_END   = 2'd1;
	localparam logic [1:0] OP_BEGIN = 2'd2;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_DRAW   = 1'b1;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] m00;
		logic signed [31:0] m10;
		logic signed [31:0] m01;
		logic signed [31:0] m11;
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic [15:0]        quad_depth;
		logic [31:0]        texture_handle;
		logic [31:0]        tex_s_range;
		logic [31:0]        tex_t_range;
		logic [31:0]        tint_rgba;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        tex_s;
		logic [15:0]        tex_t;
		logic [31:0]        vertex_tint;
		logic [3:0]         slot_index;
		logic [15:0]        vertex_depth;
		logic [13:0]        vertex_number;
		logic [14:0]        index_count;
		logic [4:0]         slots_used;
		logic               last;
	} result_t;

	typedef struct packed {
		logic       capture;
		logic       decide;
		logic       clear;
		logic       emit_draw;
		logic       emit_vtx;
		logic       last;
		logic [1:0] corner;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       emit_draw;
		logic       batch_empty;
		logic       out_free;
	} sts_t;

endpackage

// ===== rtl/qbvg_dp.sv =====
// Datapath: captured transaction, slot table with parallel match, batch counters,
// config registers, corner transform and result register.
// Depends on qbvg_pkg.
module qbvg_dp #(
	parameter int MAX_SLOTS       = qbvg_pkg::MAX_SLOTS_DEF,
	parameter int MAX_BATCH_QUADS = qbvg_pkg::MAX_BATCH_QUADS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  qbvg_pkg::item_t                 item,
	input  logic                            cfg_we,
	input  logic [qbvg_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [qbvg_pkg::CFG_DW-1:0]     cfg_data,
	input  qbvg_pkg::cmd_t                  cmd,
	output qbvg_pkg::sts_t                  sts,
	output logic                            result_valid,
	input  logic                            result_ready,
	output qbvg_pkg::result_t               result
);
	import qbvg_pkg::*;

	localparam int SW  = $clog2(MAX_SLOTS + 1);
	localparam int IW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int QW  = $clog2(MAX_BATCH_QUADS + 1);
	localparam int EQW = ((QW > BQ_W) ? QW : BQ_W) + 1;
	localparam int ESW = ((SW > SL_W) ? SW : SL_W) + 1;

	item_t                 item_q;
	logic [31:0]           table_q [MAX_SLOTS];
	logic [MAX_SLOTS-1:0]  match_q;
	logic [SW-1:0]         sa_q;
	logic [QW-1:0]         quads_q;
	logic [BQ_W-1:0]       bq_q;
	logic [SL_W-1:0]       sl_q;
	logic                  append_q;
	logic [IW-1:0]         slot_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic [EQW-1:0] bq_x, eff_q;
	logic [ESW-1:0] sl_x, eff_s;
	logic           quad_full, slots_full, found, need_draw, reuse, out_free;
	logic [IW-1:0]  hit_idx;

	logic                cx, cy;
	logic signed [33:0]  ax, bx, ay, by, sum_x, sum_y;
	logic [31:0]         pos_x, pos_y;
	logic [IW+3:0]       slot_wide;
	logic [QW+15:0]      vnum_wide;
	logic [QW+17:0]      icnt_wide;
	logic [SW+4:0]       used_wide;
	result_t             draw_r, vtx_r;

	assign bq_x  = EQW'(bq_q);
	assign eff_q = (bq_q == '0) ? EQW'(1) :
		((bq_x > EQW'(MAX_BATCH_QUADS)) ? EQW'(MAX_BATCH_QUADS) : bq_x);
	assign sl_x  = ESW'(sl_q);
	assign eff_s = (sl_q == '0) ? ESW'(1) :
		((sl_x > ESW'(MAX_SLOTS)) ? ESW'(MAX_SLOTS) : sl_x);

	assign quad_full  = (EQW'(quads_q) + EQW'(1)) > eff_q;
	assign slots_full = ESW'(sa_q) >= eff_s;

	// highest matching slot wins
	always_comb begin
		found   = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (match_q[i]) begin
				found   = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	assign need_draw = quad_full || (!found && slots_full);
	assign reuse     = found && !quad_full;
	assign out_free  = !out_valid_q || result_ready;

	assign sts.op          = item_q.op;
	assign sts.emit_draw   = need_draw && (quads_q != '0);
	assign sts.batch_empty = (quads_q == '0);
	assign sts.out_free    = out_free;

	// corner: x positive on 1,2; y positive on 2,3
	assign cx    = cmd.corner[0] ^ cmd.corner[1];
	assign cy    = cmd.corner[1];
	assign ax    = 34'(item_q.m00);
	assign bx    = 34'(item_q.m01);
	assign ay    = 34'(item_q.m10);
	assign by    = 34'(item_q.m11);
	assign sum_x = (cx ? ax : -ax) + (cy ? bx : -bx);
	assign sum_y = (cx ? ay : -ay) + (cy ? by : -by);
	assign pos_x = sum_x[32:1] + item_q.move_x;
	assign pos_y = sum_y[32:1] + item_q.move_y;

	assign slot_wide = {4'b0, slot_q};
	assign vnum_wide = {14'b0, quads_q, cmd.corner};
	assign icnt_wide = {15'b0, quads_q, 3'b0} - {15'b0, 2'b0, quads_q, 1'b0};
	assign used_wide = {5'b0, sa_q};

	always_comb begin
		draw_r             = '0;
		draw_r.kind        = KIND_DRAW;
		draw_r.index_count = icnt_wide[14:0];
		draw_r.slots_used  = used_wide[4:0];
		draw_r.last        = cmd.last;

		vtx_r               = '0;
		vtx_r.kind          = KIND_VERTEX;
		vtx_r.pos_x         = pos_x;
		vtx_r.pos_y         = pos_y;
		vtx_r.tex_s         = cx ? item_q.tex_s_range[31:16] : item_q.tex_s_range[15:0];
		vtx_r.tex_t         = cy ? item_q.tex_t_range[31:16] : item_q.tex_t_range[15:0];
		vtx_r.vertex_tint   = item_q.tint_rgba;
		vtx_r.slot_index    = slot_wide[3:0];
		vtx_r.vertex_depth  = item_q.quad_depth;
		vtx_r.vertex_number = vnum_wide[13:0];
		vtx_r.last          = (cmd.corner == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_q        <= '0;
			quads_q     <= '0;
			bq_q        <= BQ_RESET;
			sl_q        <= SL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BATCH_QUADS: bq_q <= cfg_data[BQ_W-1:0];
					CFG_SLOT_LIMIT:  sl_q <= cfg_data[SL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clear || cmd.emit_draw) begin
				sa_q    <= '0;
				quads_q <= '0;
			end else if (cmd.emit_vtx) begin
				if (cmd.corner == 2'd0 && append_q)
					sa_q <= SW'(slot_q) + SW'(1);
				if (cmd.corner == 2'd3)
					quads_q <= quads_q + QW'(1);
			end
			if (cmd.emit_draw || cmd.emit_vtx)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
			for (int i = 0; i < MAX_SLOTS; i++)
				match_q[i] <= (table_q[i] == item.texture_handle) && (SW'(i) < sa_q);
		end
		if (cmd.decide) begin
			append_q <= !reuse;
			slot_q   <= reuse ? hit_idx : (need_draw ? '0 : sa_q[IW-1:0]);
		end
		if (cmd.emit_vtx && cmd.corner == 2'd0 && append_q)
			table_q[slot_q] <= item_q.texture_handle;
		if (cmd.emit_draw)
			out_q <= draw_r;
		else if (cmd.emit_vtx)
			out_q <= vtx_r;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== rtl/qbvg_ctrl.sv =====
// Controller: state machine sequencing capture, batch decision, draw and vertex emission.
// Depends on qbvg_pkg.
module qbvg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  qbvg_pkg::sts_t  sts,
	output qbvg_pkg::cmd_t  cmd
);
	import qbvg_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DISP = 2'd1;
	localparam logic [1:0] S_DRAW = 2'd2;
	localparam logic [1:0] S_VTX  = 2'd3;

	logic [1:0] state_q, state_d;
	logic [1:0] corner_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.corner = corner_q;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					OP_QUAD: begin
						cmd.decide = 1'b1;
						state_d    = sts.emit_draw ? S_DRAW : S_VTX;
					end
					OP_END: begin
						if (sts.batch_empty) begin
							cmd.clear = 1'b1;
							state_d   = S_IDLE;
						end else if (sts.out_free) begin
							cmd.emit_draw = 1'b1;
							cmd.last      = 1'b1;
							state_d       = S_IDLE;
						end
					end
					OP_BEGIN: begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_DRAW: begin
				if (sts.out_free) begin
					cmd.emit_draw = 1'b1;
					state_d       = S_VTX;
				end
			end
			S_VTX: begin
				if (sts.out_free) begin
					cmd.emit_vtx = 1'b1;
					if (corner_q == 2'd3)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			corner_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_vtx)
				corner_q <= corner_q + 2'd1;
		end
	end

endmodule

// ===== rtl/quad_batch_vertex_generator.sv =====
// Top level of the quad batch vertex generator: controller plus datapath.
// Depends on qbvg_pkg, qbvg_ctrl, qbvg_dp.
//
//   channel   handshake                  payload
//   item      item_valid / item_ready    item   (qbvg_pkg::item_t)
//   result    result_valid / result_ready result (qbvg_pkg::result_t)
//   config    cfg_we                     cfg_index, cfg_data
//
// A quad passes accept, decide, an optional forced draw and four vertices.
// Begin/end scene: accept and dispatch. One transaction is in flight at a time;
// the result register lets the next accept overlap the last result waiting.
// Result stalls hold the sequencer at the next emission. Reset empties the batch;
// batch_quads resets to 4096 and slot_limit to 16.
module quad_batch_vertex_generator #(
	parameter int MAX_SLOTS       = qbvg_pkg::MAX_SLOTS_DEF,
	parameter int MAX_BATCH_QUADS = qbvg_pkg::MAX_BATCH_QUADS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  qbvg_pkg::item_t              item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output qbvg_pkg::result_t            result,
	input  logic                         cfg_we,
	input  logic [qbvg_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [qbvg_pkg::CFG_DW-1:0]  cfg_data
);
	import qbvg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	qbvg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	qbvg_dp #(
		.MAX_SLOTS       (MAX_SLOTS),
		.MAX_BATCH_QUADS (MAX_BATCH_QUADS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_draw_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_DRAW |->
			result.index_count != '0 && result.slots_used != '0)
		else $error("draw transaction for an empty batch");

	a_vertex_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_VERTEX |->
			result.index_count == '0 && result.slots_used == '0)
		else $error("vertex transaction carries draw fields");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("accepted a transaction while busy");

	a_single_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_draw && cmd.emit_vtx))
		else $error("draw and vertex emitted together");

endmodule
